// ===== hdl/asvm_pkg.sv =====
// ----------------------------------------------------------------------------
// asvm_pkg
// Shared types and codes for the accumulator/stack VM execute unit.
// ----------------------------------------------------------------------------
package asvm_pkg;

	typedef enum logic [4:0] {
		OP_LDR  = 5'd1,  OP_STR  = 5'd2,  OP_SREG = 5'd3,  OP_ADD  = 5'd4,
		OP_SUB  = 5'd5,  OP_MUL  = 5'd6,  OP_DIV  = 5'd7,  OP_MOD  = 5'd8,
		OP_INC  = 5'd9,  OP_DEC  = 5'd10, OP_NEG  = 5'd11, OP_AND  = 5'd12,
		OP_OR   = 5'd13, OP_XOR  = 5'd14, OP_B    = 5'd15, OP_BL   = 5'd16,
		OP_BZ   = 5'd17, OP_BN   = 5'd18, OP_INT  = 5'd19, OP_HALT = 5'd20,
		OP_PUSH = 5'd21, OP_POP  = 5'd22, OP_SLP  = 5'd23, OP_RET  = 5'd24,
		OP_LSP  = 5'd25
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0, ST_OPR  = 3'd1, ST_PC   = 3'd2, ST_SP   = 3'd3,
		ST_HALT = 3'd4, ST_ILL  = 3'd5, ST_DIV0 = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE, S_EXEC, S_DIV, S_DONE
	} seq_state_t;

	typedef struct packed {
		logic               mode;
		logic        [4:0]  opcode;
		logic signed [31:0] operand;
		logic        [9:0]  load_address;
		logic signed [31:0] load_value;
	} cmd_item_t;

	typedef struct packed {
		logic        [2:0]  status;
		logic signed [31:0] accumulator;
		logic        [8:0]  next_pc;
		logic               interrupt_valid;
		logic        [3:0]  interrupt_number;
		logic        [30:0] sleep_ticks;
	} rsp_item_t;

	// divider handshake
	typedef struct packed {
		logic start;
		logic is_mod;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== hdl/asvm_if.sv =====
// ----------------------------------------------------------------------------
// asvm_cmd_if / asvm_rsp_if
// Valid/ready channels carrying instruction items and result items.
// ----------------------------------------------------------------------------
interface asvm_cmd_if import asvm_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface asvm_rsp_if import asvm_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/asvm_alu.sv =====
// ----------------------------------------------------------------------------
// asvm_alu
// Combinational ALU for the non-dividing accumulator operations.
// ----------------------------------------------------------------------------
module asvm_alu import asvm_pkg::*; (
	input  logic [4:0]  op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	logic [31:0] prod;

	// keep only the low word of the product
	assign prod = a * b;

	// select the operation, wrapping at 32 bits
	always_comb begin
		unique case (opcode_t'(op))
			OP_ADD:  y = a + b;
			OP_SUB:  y = a - b;
			OP_MUL:  y = prod;
			OP_INC:  y = a + 32'd1;
			OP_DEC:  y = a - 32'd1;
			OP_NEG:  y = 32'd0 - a;
			OP_AND:  y = a & b;
			OP_OR:   y = a | b;
			OP_XOR:  y = a ^ b;
			default: y = a;
		endcase
	end
endmodule

// ===== hdl/asvm_div.sv =====
// ----------------------------------------------------------------------------
// asvm_div
// Iterative signed divider, one quotient bit per cycle, truncating toward 0.
// ----------------------------------------------------------------------------
module asvm_div import asvm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_ctl_t    ctl,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output div_sts_t    sts,
	output logic [31:0] result
);
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        mod_q;
	logic        negq_q;
	logic        negr_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] shifted;
	logic [33:0] diff;
	logic [31:0] abs_a;
	logic [31:0] abs_b;

	assign abs_a   = dividend[31] ? 32'd0 - dividend : dividend;
	assign abs_b   = divisor[31] ? 32'd0 - divisor : divisor;
	assign shifted = {rem_q, quo_q[31]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	// control: run 32 steps after start, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: restoring shift-subtract on magnitudes
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= '0;
			quo_q  <= abs_a;
			dvs_q  <= abs_b;
			mod_q  <= ctl.is_mod;
			negq_q <= dividend[31] ^ divisor[31];
			negr_q <= dividend[31];
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// apply signs
	always_comb begin
		if (mod_q)
			result = negr_q ? 32'd0 - rem_q : rem_q;
		else
			result = negq_q ? 32'd0 - quo_q : quo_q;
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> $past(busy_q)) else $error("divider done without run");
endmodule

// ===== hdl/accumulator_stack_vm_execute.sv =====
// ----------------------------------------------------------------------------
// accumulator_stack_vm_execute
// Execute unit of an accumulator-plus-stack VM with word memory and stack.
// ----------------------------------------------------------------------------
// channel | dir | payload
// cmd     | in  | mode, opcode, operand, load_address, load_value
// rsp     | out | status, accumulator, next_pc, interrupt_*, sleep_ticks
//
// An item passes accept (memory read), execute and commit; non-faulting div and mod
// also wait in S_DIV for the 32-step divider. One memory read, at most one write per item.
// cmd.ready is high only while idle; a result waiting in the output register
// does not block the next accept, but commit waits until that register frees.
// arst_n resets the state registers; memory contents are undefined until written.
// ----------------------------------------------------------------------------
module accumulator_stack_vm_execute import asvm_pkg::*; #(
	parameter int unsigned MEM_WORDS   = 1024,
	parameter int unsigned ROM_WORDS   = 512,
	parameter int unsigned STACK_WORDS = 256,
	parameter int unsigned IRQ_COUNT   = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	asvm_cmd_if.sink   cmd,
	asvm_rsp_if.source rsp
);
	localparam int          AW      = $clog2(MEM_WORDS);
	localparam logic [31:0] MEM_LIM = 32'(MEM_WORDS);
	localparam logic [31:0] ROM_LIM = 32'(ROM_WORDS);
	localparam logic [31:0] IRQ_LIM = 32'(IRQ_COUNT);
	localparam logic [31:0] SP_TOP  = 32'(MEM_WORDS - 1);
	localparam logic [31:0] SP_LOW  = 32'(MEM_WORDS - STACK_WORDS);

	seq_state_t  st_q, st_nx;
	cmd_item_t   item_q;
	logic [31:0] acc_q;
	logic [8:0]  pc_q;
	logic [8:0]  link_q;
	logic [AW-1:0] sp_q;
	logic [31:0] mem_q [MEM_WORDS];
	logic [AW-1:0] rd_addr;
	logic [31:0] rd_data_q;

	// pending results of the current item
	rsp_item_t   pend_q;
	logic [AW-1:0] sp_nx_q;
	logic [8:0]  link_nx_q;
	logic        we_q;
	logic [AW-1:0] wa_q;
	logic [31:0] wd_q;

	rsp_item_t   out_q;
	logic        vld_q;

	// execute-stage combinational results
	rsp_item_t   ex;
	logic [AW-1:0] ex_sp;
	logic [8:0]  ex_link;
	logic        ex_we;
	logic [AW-1:0] ex_wa;
	logic [31:0] ex_wd;
	logic        ex_div;

	logic [31:0] alu_y;
	logic [31:0] div_y;
	div_ctl_t    div_ctl;
	div_sts_t    div_sts;

	logic        accept;
	logic        out_free;
	logic [31:0] pc_w;
	logic [31:0] sp_w;
	logic [31:0] opd_u;
	logic [31:0] lsp_idx;
	logic [8:0]  pc_inc;
	logic [8:0]  link_inc;
	logic [31:0] in_lsp_idx;
	logic        binop;

	assign accept   = cmd.valid && cmd.ready;
	assign out_free = !vld_q || rsp.ready;
	assign cmd.ready = (st_q == S_IDLE);

	// pick the read address from the incoming item
	assign in_lsp_idx = {{(32-AW){1'b0}}, sp_q} + cmd.data.operand - 32'd1;
	always_comb begin
		unique case (opcode_t'(cmd.data.opcode))
			OP_LDR:  rd_addr = cmd.data.operand[AW-1:0];
			OP_LSP:  rd_addr = in_lsp_idx[AW-1:0];
			default: rd_addr = sp_q + AW'(1);
		endcase
	end

	// memory: one registered read at accept, at most one write at commit
	always_ff @(posedge clk) begin
		if (accept)
			rd_data_q <= mem_q[rd_addr];
		if (st_q == S_DONE && out_free && we_q)
			mem_q[wa_q] <= wd_q;
	end

	asvm_alu u_alu (
		.op (item_q.opcode),
		.a  (acc_q),
		.b  (rd_data_q),
		.y  (alu_y)
	);

	assign div_ctl.start  = (st_q == S_EXEC) && ex_div;
	assign div_ctl.is_mod = (opcode_t'(item_q.opcode) == OP_MOD);

	asvm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (acc_q),
		.divisor  (rd_data_q),
		.sts      (div_sts),
		.result   (div_y)
	);

	// execute: decide status, next state and result fields
	assign pc_w     = {23'd0, pc_q} + 32'd1;
	assign pc_inc   = (pc_w >= ROM_LIM) ? 9'd0 : pc_w[8:0];
	assign link_inc = (({23'd0, link_q} + 32'd1) >= ROM_LIM) ? 9'd0 : link_q + 9'd1;
	assign sp_w     = {{(32-AW){1'b0}}, sp_q};
	assign opd_u    = item_q.operand;
	assign lsp_idx  = sp_w + opd_u - 32'd1;
	assign binop    = (opcode_t'(item_q.opcode) == OP_ADD) ||
	                  (opcode_t'(item_q.opcode) == OP_SUB) ||
	                  (opcode_t'(item_q.opcode) == OP_MUL) ||
	                  (opcode_t'(item_q.opcode) == OP_DIV) ||
	                  (opcode_t'(item_q.opcode) == OP_MOD) ||
	                  (opcode_t'(item_q.opcode) == OP_AND) ||
	                  (opcode_t'(item_q.opcode) == OP_OR)  ||
	                  (opcode_t'(item_q.opcode) == OP_XOR);

	always_comb begin
		ex.status           = ST_OK;
		ex.accumulator      = acc_q;
		ex.next_pc          = pc_inc;
		ex.interrupt_valid  = 1'b0;
		ex.interrupt_number = 4'd0;
		ex.sleep_ticks      = 31'd0;
		ex_sp   = sp_q;
		ex_link = link_q;
		ex_we   = 1'b0;
		ex_wa   = item_q.load_address[AW-1:0];
		ex_wd   = item_q.load_value;
		ex_div  = 1'b0;
		if (item_q.mode) begin
			ex_we      = ({22'd0, item_q.load_address} < MEM_LIM);
			ex.next_pc = pc_q;
		end else if (binop) begin
			if (sp_w >= SP_TOP)
				ex.status = ST_SP;
			else if ((opcode_t'(item_q.opcode) == OP_DIV ||
			          opcode_t'(item_q.opcode) == OP_MOD) && rd_data_q == 32'd0)
				ex.status = ST_DIV0;
			else begin
				ex_sp = sp_q + AW'(1);
				ex.accumulator = alu_y;
				ex_div = (opcode_t'(item_q.opcode) == OP_DIV ||
				          opcode_t'(item_q.opcode) == OP_MOD);
			end
		end else begin
			unique case (opcode_t'(item_q.opcode))
				OP_LDR: begin
					if (opd_u >= MEM_LIM) ex.status = ST_OPR;
					else ex.accumulator = rd_data_q;
				end
				OP_STR: begin
					if (opd_u >= MEM_LIM) ex.status = ST_OPR;
					else begin
						ex_we = 1'b1;
						ex_wa = opd_u[AW-1:0];
						ex_wd = acc_q;
					end
				end
				OP_SREG: ex.accumulator = opd_u;
				OP_INC, OP_DEC, OP_NEG: ex.accumulator = alu_y;
				OP_B, OP_BL, OP_BZ, OP_BN: begin
					if (opd_u[31] || opd_u >= ROM_LIM)
						ex.status = ST_PC;
					else begin
						if (opcode_t'(item_q.opcode) == OP_BL)
							ex_link = pc_q;
						if ((opcode_t'(item_q.opcode) != OP_BZ || acc_q == 32'd0) &&
						    (opcode_t'(item_q.opcode) != OP_BN || acc_q[31]))
							ex.next_pc = opd_u[8:0];
					end
				end
				OP_INT: begin
					if (opd_u[31] || opd_u >= IRQ_LIM) ex.status = ST_OPR;
					else begin
						ex.interrupt_valid  = 1'b1;
						ex.interrupt_number = opd_u[3:0];
					end
				end
				OP_HALT: ex.status = ST_HALT;
				OP_PUSH: begin
					if (sp_w < SP_LOW || sp_w == 32'd0) ex.status = ST_SP;
					else begin
						ex_we = 1'b1;
						ex_wa = sp_q;
						ex_wd = acc_q;
						ex_sp = sp_q - AW'(1);
					end
				end
				OP_POP: begin
					if (sp_w >= SP_TOP) ex.status = ST_SP;
					else begin
						ex_sp = sp_q + AW'(1);
						ex.accumulator = rd_data_q;
					end
				end
				OP_SLP: begin
					if (opd_u[31]) ex.status = ST_OPR;
					else ex.sleep_ticks = opd_u[30:0];
				end
				OP_RET: begin
					if (sp_w < SP_LOW) ex.status = ST_SP;
					else ex.next_pc = link_inc;
				end
				OP_LSP: begin
					if (lsp_idx >= MEM_LIM) ex.status = ST_OPR;
					else ex.accumulator = rd_data_q;
				end
				default: ex.status = ST_ILL;
			endcase
		end
		// errors leave all state untouched
		if (ex.status != ST_OK) begin
			ex.next_pc     = pc_q;
			ex.accumulator = acc_q;
			ex_sp          = sp_q;
			ex_link        = link_q;
			ex_we          = 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_nx;
	end

	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			S_IDLE: if (accept) st_nx = S_EXEC;
			S_EXEC: st_nx = ex_div ? S_DIV : S_DONE;
			S_DIV:  if (div_sts.done) st_nx = S_DONE;
			S_DONE: if (out_free) st_nx = S_IDLE;
			default: st_nx = S_IDLE;
		endcase
	end

	// capture the item and the pending result
	always_ff @(posedge clk) begin
		if (accept)
			item_q <= cmd.data;
		if (st_q == S_EXEC) begin
			pend_q    <= ex;
			sp_nx_q   <= ex_sp;
			link_nx_q <= ex_link;
			we_q      <= ex_we;
			wa_q      <= ex_wa;
			wd_q      <= ex_wd;
		end else if (st_q == S_DIV && div_sts.done) begin
			pend_q.accumulator <= div_y;
		end
		if (st_q == S_DONE && out_free)
			out_q <= pend_q;
	end

	// commit architectural state and hand the result to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pc_q   <= '0;
			link_q <= '0;
			sp_q   <= AW'(MEM_WORDS - 1);
			vld_q  <= 1'b0;
		end else begin
			if (st_q == S_DONE && out_free) begin
				acc_q  <= pend_q.accumulator;
				pc_q   <= pend_q.next_pc;
				link_q <= link_nx_q;
				sp_q   <= sp_nx_q;
				vld_q  <= 1'b1;
			end else if (rsp.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = vld_q;
	assign rsp.data  = out_q;

	a_rsp_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.next_pc == pc_q && rsp.data.accumulator == acc_q))
		else $error("shown result differs from committed state");
	a_sp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{{(32-AW){1'b0}}, sp_q} <= SP_TOP) else $error("stack pointer out of range");
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |=> div_sts.busy) else $error("divider failed to start");
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DONE && out_free) |=> rsp.valid) else $error("commit without result");
endmodule
